// File: rtl/bbsc_pkg.sv
// Shared constants, types and helpers for the band-stop cascade.
// Used by bbsc_mul, bbsc_cell and butterworth_bandstop_cascade; no dependencies.
package bbsc_pkg;

    localparam int SECTIONS       = 4;
    localparam int COEF_FRAC_BITS = 28;
    localparam int SAMPLE_BITS    = 24;

    localparam int STATE_W    = 48;
    localparam int STATE_FRAC = 16;
    localparam int COEF_W     = 32;
    localparam int MID_W      = 31;
    localparam int MUL_SPLIT  = 24;
    localparam int HI_W       = STATE_W - MUL_SPLIT;
    localparam int PP_HI_W    = COEF_W + HI_W;
    localparam int PP_LO_W    = COEF_W + MUL_SPLIT + 1;
    localparam int FULL_W     = COEF_W + STATE_W;

    // products are clamped only when the fraction shift is below the split point
    localparam bit CLAMP_ON   = (COEF_FRAC_BITS < MUL_SPLIT);
    localparam int CLAMP_M    = CLAMP_ON ? (MUL_SPLIT - COEF_FRAC_BITS) : 0;
    localparam int PROD_LIM_LOG = 60;
    localparam int PROD_W     = CLAMP_ON ? (PROD_LIM_LOG + 2) : (FULL_W - COEF_FRAC_BITS);
    localparam int ACC_W      = PROD_W + 3;
    localparam logic signed [FULL_W-1:0] PROD_LIM =
        FULL_W'(64'sd1 <<< PROD_LIM_LOG);
    localparam logic signed [FULL_W-1:0] CLAMP_T =
        FULL_W'(64'sd1 <<< (PROD_LIM_LOG - CLAMP_M));

    localparam logic signed [ACC_W-1:0] ACC_STATE_MAX =
        {{(ACC_W-STATE_W+1){1'b0}}, {(STATE_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_STATE_MIN =
        {{(ACC_W-STATE_W+1){1'b1}}, {(STATE_W-1){1'b0}}};

    // output rounding and clamp
    localparam int Y_W = STATE_W + 1 - STATE_FRAC;
    localparam logic signed [STATE_W:0] ROUND_HALF = (STATE_W+1)'(1) << (STATE_FRAC - 1);
    localparam logic signed [Y_W-1:0] Y_MAX =
        {{(Y_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [Y_W-1:0] Y_MIN =
        {{(Y_W-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};

    // stream word layout
    localparam int SEC_W      = 2;
    localparam int SEL_W      = 3;
    localparam int SEC_LSB    = 0;
    localparam int SEL_LSB    = SEC_LSB + SEC_W;
    localparam int CVAL_LSB   = SEL_LSB + SEL_W;
    localparam int SMP_LSB    = CVAL_LSB + COEF_W;
    localparam int S_TDATA_W  = ((SMP_LSB + SAMPLE_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((SAMPLE_BITS + 7) / 8) * 8;

    // configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_ODD  = 1'b0;
    localparam logic REG_MID  = 1'b1;
    localparam logic [MID_W-1:0] MID_RESET = MID_W'(1) << 29;

    // command codes
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_LOAD   = 1'b1;

    // coefficient selects
    localparam logic [SEL_W-1:0] COEF_GAIN = 3'd0;
    localparam logic [SEL_W-1:0] COEF_D1   = 3'd1;
    localparam logic [SEL_W-1:0] COEF_D2   = 3'd2;
    localparam logic [SEL_W-1:0] COEF_D3   = 3'd3;
    localparam logic [SEL_W-1:0] COEF_D4   = 3'd4;

    // cell sequencer steps: multiply issue points and finishing steps
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] MUL_LAT  = 4'd2;
    localparam logic [STEP_W-1:0] STP_ODD1 = 4'd0;
    localparam logic [STEP_W-1:0] STP_MID  = 4'd1;
    localparam logic [STEP_W-1:0] STP_ODD3 = 4'd2;
    localparam logic [STEP_W-1:0] STP_FB1  = 4'd3;
    localparam logic [STEP_W-1:0] STP_FB2  = 4'd4;
    localparam logic [STEP_W-1:0] STP_FB3  = 4'd5;
    localparam logic [STEP_W-1:0] STP_FB4  = 4'd6;
    localparam logic [STEP_W-1:0] STP_W0   = 4'd9;
    localparam logic [STEP_W-1:0] STP_FF   = 4'd10;
    localparam logic [STEP_W-1:0] STP_GAIN = 4'd11;

    typedef struct packed {
        logic                       en;
        logic [SEL_W-1:0]           sel;
        logic signed [COEF_W-1:0]   value;
    } coef_wr_t;

    typedef struct packed {
        logic                       valid;
        logic                       clip;
        logic signed [STATE_W-1:0]  x;
    } stage_word_t;

    typedef struct packed {
        logic                       clip;
        logic signed [STATE_W-1:0]  v;
    } sat_t;

    function automatic logic signed [ACC_W-1:0] acc_from_state(
        input logic signed [STATE_W-1:0] v);
        return {{(ACC_W-STATE_W){v[STATE_W-1]}}, v};
    endfunction

    function automatic logic signed [ACC_W-1:0] acc_from_prod(
        input logic signed [PROD_W-1:0] v);
        return {{(ACC_W-PROD_W){v[PROD_W-1]}}, v};
    endfunction

    function automatic sat_t sat_state(input logic signed [ACC_W-1:0] v);
        sat_t r;
        if (v > ACC_STATE_MAX) begin
            r.clip = 1'b1;
            r.v    = ACC_STATE_MAX[STATE_W-1:0];
        end else if (v < ACC_STATE_MIN) begin
            r.clip = 1'b1;
            r.v    = ACC_STATE_MIN[STATE_W-1:0];
        end else begin
            r.clip = 1'b0;
            r.v    = v[STATE_W-1:0];
        end
        return r;
    endfunction

endpackage

// File: rtl/bbsc_mul.sv
// Two-stage coefficient by state multiplier, split into a 32x24 and a 32x25 partial product.
// Depends on bbsc_pkg.
module bbsc_mul (
    input  logic                                 aclk,
    input  logic signed [bbsc_pkg::COEF_W-1:0]   coef,
    input  logic signed [bbsc_pkg::STATE_W-1:0]  state,
    output logic signed [bbsc_pkg::PROD_W-1:0]   prod
);

    logic signed [bbsc_pkg::PP_HI_W-1:0] pp_hi_reg;
    logic signed [bbsc_pkg::PP_LO_W-1:0] pp_lo_reg;
    logic signed [bbsc_pkg::PP_HI_W-1:0] pp_hi_next;
    logic signed [bbsc_pkg::PP_LO_W-1:0] pp_lo_next;
    logic signed [bbsc_pkg::FULL_W-1:0]  full;
    logic signed [bbsc_pkg::FULL_W-1:0]  quot;
    logic signed [bbsc_pkg::FULL_W-1:0]  trunc24;
    logic signed [bbsc_pkg::FULL_W-1:0]  prod_full;
    logic signed [bbsc_pkg::PROD_W-1:0]  prod_reg;
    logic signed [bbsc_pkg::PROD_W-1:0]  prod_next;

    assign pp_hi_next = coef * $signed(state[bbsc_pkg::STATE_W-1:bbsc_pkg::MUL_SPLIT]);
    assign pp_lo_next = coef * $signed({1'b0, state[bbsc_pkg::MUL_SPLIT-1:0]});

    always_comb begin
        full = ($signed({{(bbsc_pkg::FULL_W-bbsc_pkg::PP_HI_W){pp_hi_reg[bbsc_pkg::PP_HI_W-1]}},
                         pp_hi_reg}) <<< bbsc_pkg::MUL_SPLIT)
             + $signed({{(bbsc_pkg::FULL_W-bbsc_pkg::PP_LO_W){pp_lo_reg[bbsc_pkg::PP_LO_W-1]}},
                         pp_lo_reg});
        quot    = full >>> bbsc_pkg::COEF_FRAC_BITS;
        trunc24 = full >>> bbsc_pkg::MUL_SPLIT;
        prod_full = quot;
        if (bbsc_pkg::CLAMP_ON) begin
            if (trunc24 > bbsc_pkg::CLAMP_T) begin
                prod_full = bbsc_pkg::PROD_LIM;
            end else if (trunc24 < -bbsc_pkg::CLAMP_T) begin
                prod_full = -bbsc_pkg::PROD_LIM;
            end
        end
        prod_next = prod_full[bbsc_pkg::PROD_W-1:0];
    end

    always_ff @(posedge aclk) begin
        pp_hi_reg <= pp_hi_next;
        pp_lo_reg <= pp_lo_next;
        prod_reg  <= prod_next;
    end

    assign prod = prod_reg;

endmodule

// File: rtl/bbsc_cell.sv
// One fourth-order section: delay line, coefficients and a stepped multiply-accumulate.
// Depends on bbsc_pkg and bbsc_mul.
module bbsc_cell (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  bbsc_pkg::stage_word_t                stage_in,
    input  bbsc_pkg::coef_wr_t                   coef_wr,
    input  logic signed [bbsc_pkg::COEF_W-1:0]   num_odd,
    input  logic [bbsc_pkg::MID_W-1:0]           num_mid,
    output bbsc_pkg::stage_word_t                stage_out
);

    localparam int SW = bbsc_pkg::STATE_W;
    localparam int CW = bbsc_pkg::COEF_W;
    localparam int AW = bbsc_pkg::ACC_W;

    logic signed [SW-1:0] dly1_reg, dly2_reg, dly3_reg, dly4_reg;
    logic signed [SW-1:0] dly1_next, dly2_next, dly3_next, dly4_next;
    logic signed [CW-1:0] gain_reg, gain_next;
    logic signed [CW-1:0] fb_reg  [4];
    logic signed [CW-1:0] fb_next [4];
    logic                 run_reg, run_next;
    logic                 done_reg, done_next;
    logic                 clip_reg, clip_next;
    logic [bbsc_pkg::STEP_W-1:0] step_reg, step_next;
    logic signed [AW-1:0] acc_fb_reg, acc_fb_next;
    logic signed [AW-1:0] acc_ff_reg, acc_ff_next;
    logic signed [SW-1:0] w0_reg, w0_next;
    logic signed [SW-1:0] ff_reg, ff_next;
    logic signed [SW-1:0] x_reg, x_next;

    logic signed [CW-1:0] mul_coef;
    logic signed [SW-1:0] mul_state;
    logic signed [bbsc_pkg::PROD_W-1:0] prod;
    logic signed [AW-1:0] prod_acc;
    bbsc_pkg::sat_t       sat_w0, sat_ff, sat_x;

    bbsc_mul u_mul (
        .aclk  (aclk),
        .coef  (mul_coef),
        .state (mul_state),
        .prod  (prod)
    );

    // operand select per issue step
    always_comb begin
        case (step_reg)
            bbsc_pkg::STP_ODD1: begin mul_coef = num_odd;                     mul_state = dly1_reg; end
            bbsc_pkg::STP_MID:  begin mul_coef = $signed({1'b0, num_mid});   mul_state = dly2_reg; end
            bbsc_pkg::STP_ODD3: begin mul_coef = num_odd;                     mul_state = dly3_reg; end
            bbsc_pkg::STP_FB1:  begin mul_coef = fb_reg[0];                   mul_state = dly1_reg; end
            bbsc_pkg::STP_FB2:  begin mul_coef = fb_reg[1];                   mul_state = dly2_reg; end
            bbsc_pkg::STP_FB3:  begin mul_coef = fb_reg[2];                   mul_state = dly3_reg; end
            bbsc_pkg::STP_FB4:  begin mul_coef = fb_reg[3];                   mul_state = dly4_reg; end
            default:            begin mul_coef = gain_reg;                    mul_state = ff_reg;   end
        endcase
    end

    assign prod_acc = bbsc_pkg::acc_from_prod(prod);
    assign sat_w0   = bbsc_pkg::sat_state(acc_fb_reg);
    assign sat_ff   = bbsc_pkg::sat_state(bbsc_pkg::acc_from_state(w0_reg) + acc_ff_reg);
    assign sat_x    = bbsc_pkg::sat_state(prod_acc);

    always_comb begin
        run_next    = run_reg;
        done_next   = 1'b0;
        clip_next   = clip_reg;
        step_next   = step_reg;
        acc_fb_next = acc_fb_reg;
        acc_ff_next = acc_ff_reg;
        w0_next     = w0_reg;
        ff_next     = ff_reg;
        x_next      = x_reg;
        dly1_next   = dly1_reg;
        dly2_next   = dly2_reg;
        dly3_next   = dly3_reg;
        dly4_next   = dly4_reg;
        if (stage_in.valid) begin
            run_next    = 1'b1;
            step_next   = '0;
            clip_next   = stage_in.clip;
            acc_fb_next = bbsc_pkg::acc_from_state(stage_in.x);
            acc_ff_next = bbsc_pkg::acc_from_state(dly4_reg);
        end else if (run_reg) begin
            step_next = step_reg + 1'b1;
            case (step_reg)
                bbsc_pkg::STP_ODD1 + bbsc_pkg::MUL_LAT: acc_ff_next = acc_ff_reg - prod_acc;
                bbsc_pkg::STP_MID  + bbsc_pkg::MUL_LAT: acc_ff_next = acc_ff_reg + prod_acc;
                bbsc_pkg::STP_ODD3 + bbsc_pkg::MUL_LAT: acc_ff_next = acc_ff_reg - prod_acc;
                bbsc_pkg::STP_FB1  + bbsc_pkg::MUL_LAT: acc_fb_next = acc_fb_reg + prod_acc;
                bbsc_pkg::STP_FB2  + bbsc_pkg::MUL_LAT: acc_fb_next = acc_fb_reg + prod_acc;
                bbsc_pkg::STP_FB3  + bbsc_pkg::MUL_LAT: acc_fb_next = acc_fb_reg + prod_acc;
                bbsc_pkg::STP_FB4  + bbsc_pkg::MUL_LAT: acc_fb_next = acc_fb_reg + prod_acc;
                bbsc_pkg::STP_W0: begin
                    w0_next   = sat_w0.v;
                    clip_next = clip_reg | sat_w0.clip;
                end
                bbsc_pkg::STP_FF: begin
                    ff_next   = sat_ff.v;
                    clip_next = clip_reg | sat_ff.clip;
                    dly4_next = dly3_reg;
                    dly3_next = dly2_reg;
                    dly2_next = dly1_reg;
                    dly1_next = w0_reg;
                end
                bbsc_pkg::STP_GAIN + bbsc_pkg::MUL_LAT: begin
                    x_next    = sat_x.v;
                    clip_next = clip_reg | sat_x.clip;
                    run_next  = 1'b0;
                    done_next = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // coefficient load
    always_comb begin
        gain_next = gain_reg;
        for (int k = 0; k < 4; k++) begin
            fb_next[k] = fb_reg[k];
        end
        if (coef_wr.en) begin
            case (coef_wr.sel)
                bbsc_pkg::COEF_GAIN: gain_next  = coef_wr.value;
                bbsc_pkg::COEF_D1:   fb_next[0] = coef_wr.value;
                bbsc_pkg::COEF_D2:   fb_next[1] = coef_wr.value;
                bbsc_pkg::COEF_D3:   fb_next[2] = coef_wr.value;
                bbsc_pkg::COEF_D4:   fb_next[3] = coef_wr.value;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            clip_reg <= 1'b0;
            step_reg <= '0;
            dly1_reg <= '0;
            dly2_reg <= '0;
            dly3_reg <= '0;
            dly4_reg <= '0;
            gain_reg <= '0;
            for (int k = 0; k < 4; k++) begin
                fb_reg[k] <= '0;
            end
        end else begin
            run_reg  <= run_next;
            done_reg <= done_next;
            clip_reg <= clip_next;
            step_reg <= step_next;
            dly1_reg <= dly1_next;
            dly2_reg <= dly2_next;
            dly3_reg <= dly3_next;
            dly4_reg <= dly4_next;
            gain_reg <= gain_next;
            for (int k = 0; k < 4; k++) begin
                fb_reg[k] <= fb_next[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        acc_fb_reg <= acc_fb_next;
        acc_ff_reg <= acc_ff_next;
        w0_reg     <= w0_next;
        ff_reg     <= ff_next;
        x_reg      <= x_next;
    end

    assign stage_out.valid = done_reg;
    assign stage_out.clip  = clip_reg;
    assign stage_out.x     = x_reg;

endmodule

// File: rtl/butterworth_bandstop_cascade.sv
// Band-stop filter cascade: a row of section cells between a stream input and output.
// Depends on bbsc_pkg and bbsc_cell (which uses bbsc_mul).
//
// s_ words carry either a sample (s_tuser = 0) or a coefficient load (s_tuser = 1).
// A load writes gain or d1..d4 of one section in the cycle it is accepted and
// gives no m_ word. A sample passes through the cells one after another; each
// cell owns one multiplier and works through seven state products, the
// saturating sums and then the gain product. Only one sample is in the
// chain at a time: s_tready drops on a sample and rises again once its
// word moves into the output register, so a new sample is taken only after
// the last one has left the chain. A finished word held by a stalled receiver
// does not block the next sample; a second finished word waits in a holding
// register and the chain stops taking samples until it moves on.
// The APB port sets the shared numerator terms r (address 0) and s (address 4);
// write them only while no sample is in flight.
// Reset clears delay lines, coefficients, r, and sets s to 2.0; pready is always high.
module butterworth_bandstop_cascade (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // section_index, coef_select, coef_value, sample_in, zero pad
    input  logic [bbsc_pkg::S_TDATA_W-1:0]        s_tdata,
    // cmd
    input  logic                                  s_tuser,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // sample_out
    output logic [bbsc_pkg::M_TDATA_W-1:0]        m_tdata,
    // clipped
    output logic                                  m_tuser,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [bbsc_pkg::APB_ADDR_W-1:0]       paddr,
    input  logic [bbsc_pkg::APB_DATA_W-1:0]       pwdata,
    output logic [bbsc_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                  pready
);

    localparam int SB = bbsc_pkg::SAMPLE_BITS;

    logic                                  busy_reg, busy_next;
    logic                                  res_valid_reg, res_valid_next;
    logic [SB-1:0]                         res_y_reg, res_y_next;
    logic                                  res_clip_reg, res_clip_next;
    logic                                  out_valid_reg, out_valid_next;
    logic [SB-1:0]                         out_y_reg, out_y_next;
    logic                                  out_clip_reg, out_clip_next;
    logic signed [bbsc_pkg::COEF_W-1:0]    odd_reg, odd_next;
    logic [bbsc_pkg::MID_W-1:0]            mid_reg, mid_next;

    logic                                  accept, sample_go, load_go, apb_wr, res_move;
    logic [bbsc_pkg::SEC_W-1:0]            sec;
    logic signed [SB-1:0]                  sample;
    logic signed [bbsc_pkg::STATE_W:0]     round_sum;
    logic signed [bbsc_pkg::Y_W-1:0]       y_full;
    logic [bbsc_pkg::SECTIONS:0]           done_vec;
    bbsc_pkg::stage_word_t                 chain [bbsc_pkg::SECTIONS+1];
    bbsc_pkg::coef_wr_t                    coef_wr [bbsc_pkg::SECTIONS];

    assign s_tready  = !busy_reg;
    assign accept    = s_tvalid && s_tready;
    assign sample_go = accept && (s_tuser == bbsc_pkg::CMD_SAMPLE);
    assign load_go   = accept && (s_tuser == bbsc_pkg::CMD_LOAD);
    assign sec       = s_tdata[bbsc_pkg::SEL_LSB-1:bbsc_pkg::SEC_LSB];
    assign sample    = s_tdata[bbsc_pkg::SMP_LSB+SB-1:bbsc_pkg::SMP_LSB];

    assign chain[0].valid = sample_go;
    assign chain[0].clip  = 1'b0;
    assign chain[0].x     = {{(bbsc_pkg::STATE_W-SB-bbsc_pkg::STATE_FRAC){sample[SB-1]}},
                             sample, {bbsc_pkg::STATE_FRAC{1'b0}}};

    for (genvar i = 0; i < bbsc_pkg::SECTIONS; i++) begin : g_cell
        assign coef_wr[i].en    = load_go && (32'(sec) == 32'(i));
        assign coef_wr[i].sel   = s_tdata[bbsc_pkg::CVAL_LSB-1:bbsc_pkg::SEL_LSB];
        assign coef_wr[i].value = s_tdata[bbsc_pkg::SMP_LSB-1:bbsc_pkg::CVAL_LSB];

        bbsc_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .stage_in  (chain[i]),
            .coef_wr   (coef_wr[i]),
            .num_odd   (odd_reg),
            .num_mid   (mid_reg),
            .stage_out (chain[i+1])
        );
    end

    for (genvar i = 0; i <= bbsc_pkg::SECTIONS; i++) begin : g_done
        assign done_vec[i] = chain[i].valid;
    end

    // round half up, then clamp to the sample range
    always_comb begin
        round_sum = $signed({chain[bbsc_pkg::SECTIONS].x[bbsc_pkg::STATE_W-1],
                             chain[bbsc_pkg::SECTIONS].x}) + bbsc_pkg::ROUND_HALF;
        y_full    = round_sum[bbsc_pkg::STATE_W:bbsc_pkg::STATE_FRAC];
        res_clip_next = res_clip_reg;
        res_y_next    = res_y_reg;
        if (chain[bbsc_pkg::SECTIONS].valid) begin
            res_clip_next = chain[bbsc_pkg::SECTIONS].clip;
            if (y_full > bbsc_pkg::Y_MAX) begin
                res_y_next    = bbsc_pkg::Y_MAX[SB-1:0];
                res_clip_next = 1'b1;
            end else if (y_full < bbsc_pkg::Y_MIN) begin
                res_y_next    = bbsc_pkg::Y_MIN[SB-1:0];
                res_clip_next = 1'b1;
            end else begin
                res_y_next    = y_full[SB-1:0];
            end
        end
    end

    assign res_move = res_valid_reg && (!out_valid_reg || m_tready);

    always_comb begin
        busy_next      = busy_reg;
        res_valid_next = res_valid_reg;
        out_valid_next = out_valid_reg;
        out_y_next     = out_y_reg;
        out_clip_next  = out_clip_reg;
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end
        if (res_move) begin
            out_valid_next = 1'b1;
            out_y_next     = res_y_reg;
            out_clip_next  = res_clip_reg;
            res_valid_next = 1'b0;
            busy_next      = 1'b0;
        end
        if (chain[bbsc_pkg::SECTIONS].valid) begin
            res_valid_next = 1'b1;
        end
        if (sample_go) begin
            busy_next = 1'b1;
        end
    end

    assign apb_wr = psel && penable && pwrite && pready;

    always_comb begin
        odd_next = odd_reg;
        mid_next = mid_reg;
        if (apb_wr) begin
            case (paddr[2])
                bbsc_pkg::REG_ODD: odd_next = pwdata;
                bbsc_pkg::REG_MID: mid_next = pwdata[bbsc_pkg::MID_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            bbsc_pkg::REG_ODD: prdata = odd_reg;
            bbsc_pkg::REG_MID: prdata = {1'b0, mid_reg};
            default:           prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            odd_reg       <= '0;
            mid_reg       <= bbsc_pkg::MID_RESET;
        end else begin
            busy_reg      <= busy_next;
            res_valid_reg <= res_valid_next;
            out_valid_reg <= out_valid_next;
            odd_reg       <= odd_next;
            mid_reg       <= mid_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_y_reg    <= res_y_next;
        res_clip_reg <= res_clip_next;
        out_y_reg    <= out_y_next;
        out_clip_reg <= out_clip_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = bbsc_pkg::M_TDATA_W'(out_y_reg);
    assign m_tuser  = out_clip_reg;

    a_one_stage_active: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(done_vec))
        else $error("more than one cell hands off a word in the same cycle");

    a_hold_only_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid_reg |-> busy_reg)
        else $error("holding register full while the chain is idle");

    a_sample_sets_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        sample_go |=> busy_reg)
        else $error("accepted sample did not mark the chain busy");

    a_finish_into_free_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        chain[bbsc_pkg::SECTIONS].valid |-> (busy_reg && !res_valid_reg))
        else $error("chain finished into a full holding register or while idle");

endmodule

// File: tb/sv/butterworth_bandstop_cascade_test.sv
`timescale 1ns / 1ps
// Self-checking bench for butterworth_bandstop_cascade: streams samples and coefficient
// loads, predicts every filtered word in fixed point and compares it with m_ output.
// Depends on bbsc_pkg and the RTL of the cascade.
module butterworth_bandstop_cascade_test;

    localparam logic [bbsc_pkg::APB_ADDR_W-1:0] ADDR_ODD = {bbsc_pkg::REG_ODD, 2'b00};
    localparam logic [bbsc_pkg::APB_ADDR_W-1:0] ADDR_MID = {bbsc_pkg::REG_MID, 2'b00};
    localparam longint STATE_HI = (64'sd1 <<< (bbsc_pkg::STATE_W - 1)) - 1;
    localparam longint STATE_LO = -(64'sd1 <<< (bbsc_pkg::STATE_W - 1));
    localparam longint OUT_HI = (64'sd1 <<< (bbsc_pkg::SAMPLE_BITS - 1)) - 1;
    localparam longint OUT_LO = -(64'sd1 <<< (bbsc_pkg::SAMPLE_BITS - 1));
    localparam int RX_HOLD_CYCLES = 600;
    localparam int PHASES = 6;
    localparam int PHASE_WORDS = 272;

    typedef struct packed {
        logic                                    cmd;
        logic [bbsc_pkg::SEC_W-1:0]              sec;
        logic [bbsc_pkg::SEL_W-1:0]              sel;
        logic signed [bbsc_pkg::COEF_W-1:0]      cval;
        logic signed [bbsc_pkg::SAMPLE_BITS-1:0] smp;
    } stream_word_t;

    typedef struct packed {
        logic signed [bbsc_pkg::SAMPLE_BITS-1:0] smp;
        logic                                    clip;
    } filtered_word_t;

    logic aclk;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [bbsc_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic s_tuser = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [bbsc_pkg::M_TDATA_W-1:0] m_tdata;
    logic m_tuser;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [bbsc_pkg::APB_ADDR_W-1:0] paddr = '0;
    logic [bbsc_pkg::APB_DATA_W-1:0] pwdata = '0;
    logic [bbsc_pkg::APB_DATA_W-1:0] prdata;
    logic pready;

    butterworth_bandstop_cascade dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // filter state as the cascade should hold it
    logic signed [bbsc_pkg::STATE_W-1:0] tap1 [bbsc_pkg::SECTIONS] = '{default: '0};
    logic signed [bbsc_pkg::STATE_W-1:0] tap2 [bbsc_pkg::SECTIONS] = '{default: '0};
    logic signed [bbsc_pkg::STATE_W-1:0] tap3 [bbsc_pkg::SECTIONS] = '{default: '0};
    logic signed [bbsc_pkg::STATE_W-1:0] tap4 [bbsc_pkg::SECTIONS] = '{default: '0};
    logic signed [bbsc_pkg::COEF_W-1:0] gain_m [bbsc_pkg::SECTIONS] = '{default: '0};
    logic signed [bbsc_pkg::COEF_W-1:0] fb_m [bbsc_pkg::SECTIONS][4] =
        '{default: '{default: '0}};
    logic signed [bbsc_pkg::COEF_W-1:0] odd_m = '0;
    logic [bbsc_pkg::MID_W-1:0] mid_m = bbsc_pkg::MID_RESET;

    stream_word_t word_q[$];
    filtered_word_t filtered_q[$];
    stream_word_t drv_word;
    int issued_cnt = 0;
    int accepted_cnt = 0;
    int results_seen = 0;
    int errors = 0;
    int n_samples = 0;
    int n_loads = 0;
    int n_clipped = 0;
    int n_settings = 0;
    int tx_idle_pct = 12;
    int rx_idle_pct = 59;
    int hold_cnt = 0;
    bit hold_done = 1'b0;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
    end

    initial begin
        #1_500_000;
        $display("FAIL");
        $finish;
    end

    task automatic log_mismatch(input string msg);
        errors++;
        $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    function automatic longint scale_q(input logic signed [bbsc_pkg::COEF_W:0] c,
                                       input logic signed [bbsc_pkg::STATE_W-1:0] w);
        logic signed [bbsc_pkg::COEF_W+bbsc_pkg::STATE_W:0] p;
        p = c * w;
        p = p >>> bbsc_pkg::COEF_FRAC_BITS;
        return longint'(p[63:0]);
    endfunction

    function automatic logic signed [bbsc_pkg::STATE_W-1:0] clamp_state(input longint v,
                                                                       inout bit clip);
        if (v > STATE_HI) begin
            clip = 1'b1;
            return STATE_HI[bbsc_pkg::STATE_W-1:0];
        end
        if (v < STATE_LO) begin
            clip = 1'b1;
            return STATE_LO[bbsc_pkg::STATE_W-1:0];
        end
        return v[bbsc_pkg::STATE_W-1:0];
    endfunction

    task automatic filter_model_step(input stream_word_t w);
        longint x;
        longint y;
        logic signed [bbsc_pkg::STATE_W-1:0] w0;
        logic signed [bbsc_pkg::STATE_W-1:0] ff;
        logic signed [bbsc_pkg::COEF_W:0] mid_s;
        bit clip;
        filtered_word_t res;
        if (w.cmd == bbsc_pkg::CMD_LOAD) begin
            n_loads++;
            if (w.sec < bbsc_pkg::SECTIONS) begin
                if (w.sel == bbsc_pkg::COEF_GAIN)
                    gain_m[w.sec] = w.cval;
                else if (w.sel <= bbsc_pkg::COEF_D4)
                    fb_m[w.sec][w.sel - 1] = w.cval;
            end
            return;
        end
        n_samples++;
        clip = 1'b0;
        mid_s = $signed({2'b00, mid_m});
        x = longint'(w.smp) * (64'sd1 <<< bbsc_pkg::STATE_FRAC);
        x = clamp_state(x, clip);
        for (int i = 0; i < bbsc_pkg::SECTIONS; i++) begin
            w0 = clamp_state(scale_q(fb_m[i][0], tap1[i]) + scale_q(fb_m[i][1], tap2[i])
                             + scale_q(fb_m[i][2], tap3[i]) + scale_q(fb_m[i][3], tap4[i])
                             + x, clip);
            ff = clamp_state(longint'(w0) - scale_q(odd_m, tap1[i])
                             + scale_q(mid_s, tap2[i]) - scale_q(odd_m, tap3[i])
                             + longint'(tap4[i]), clip);
            x = clamp_state(scale_q(gain_m[i], ff), clip);
            tap4[i] = tap3[i];
            tap3[i] = tap2[i];
            tap2[i] = tap1[i];
            tap1[i] = w0;
        end
        y = (x + (64'sd1 <<< (bbsc_pkg::STATE_FRAC - 1))) >>> bbsc_pkg::STATE_FRAC;
        if (y > OUT_HI) begin
            y = OUT_HI;
            clip = 1'b1;
        end
        if (y < OUT_LO) begin
            y = OUT_LO;
            clip = 1'b1;
        end
        res.smp = y[bbsc_pkg::SAMPLE_BITS-1:0];
        res.clip = clip;
        filtered_q.push_back(res);
    endtask

    // sender: hold the word until it is taken, then maybe idle
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) begin
                filter_model_step(drv_word);
                accepted_cnt++;
            end
            if (word_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                drv_word = word_q.pop_front();
                s_tdata <= bbsc_pkg::S_TDATA_W'({drv_word.smp, drv_word.cval,
                                                 drv_word.sel, drv_word.sec});
                s_tuser <= drv_word.cmd;
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: random stalls plus one long hold-off while words are still queued
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            m_tready <= 1'b0;
        end else if (!hold_done && results_seen >= 150 && word_q.size() > 20) begin
            hold_done <= 1'b1;
            hold_cnt <= RX_HOLD_CYCLES;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge aclk) begin : check_out
        filtered_word_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (m_tuser)
                n_clipped++;
            if (filtered_q.size() == 0) begin
                log_mismatch("output word with nothing expected");
            end else begin
                want = filtered_q.pop_front();
                if (m_tdata[bbsc_pkg::SAMPLE_BITS-1:0] !== want.smp)
                    log_mismatch($sformatf("sample_out %0d, expected %0d",
                                           $signed(m_tdata[bbsc_pkg::SAMPLE_BITS-1:0]),
                                           want.smp));
                if (m_tuser !== want.clip)
                    log_mismatch($sformatf("clipped %b, expected %b", m_tuser, want.clip));
            end
        end
    end

    task automatic apb_access(input logic wr, input logic [bbsc_pkg::APB_ADDR_W-1:0] addr,
                              input logic [bbsc_pkg::APB_DATA_W-1:0] wdata,
                              output logic [bbsc_pkg::APB_DATA_W-1:0] rdata);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= addr;
        pwdata <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic check_numerators();
        logic [bbsc_pkg::APB_DATA_W-1:0] rd;
        apb_access(1'b0, ADDR_ODD, '0, rd);
        if (rd !== odd_m)
            log_mismatch($sformatf("odd term reads %h, expected %h", rd, odd_m));
        apb_access(1'b0, ADDR_MID, '0, rd);
        if (rd !== {1'b0, mid_m})
            log_mismatch($sformatf("middle term reads %h, expected %h", rd, mid_m));
    endtask

    task automatic set_numerators(input logic signed [bbsc_pkg::COEF_W-1:0] odd,
                                  input logic [bbsc_pkg::MID_W-1:0] mid);
        logic [bbsc_pkg::APB_DATA_W-1:0] rd;
        apb_access(1'b1, ADDR_ODD, odd, rd);
        odd_m = odd;
        apb_access(1'b1, ADDR_MID, {1'b0, mid}, rd);
        mid_m = mid;
        n_settings++;
        check_numerators();
    endtask

    task automatic wait_drained();
        while (accepted_cnt != issued_cnt || filtered_q.size() != 0)
            @(posedge aclk);
    endtask

    task automatic push_load(input int sec, input logic [bbsc_pkg::SEL_W-1:0] sel,
                             input int val);
        stream_word_t w;
        w.cmd = bbsc_pkg::CMD_LOAD;
        w.sec = bbsc_pkg::SEC_W'(sec);
        w.sel = sel;
        w.cval = val;
        w.smp = bbsc_pkg::SAMPLE_BITS'($urandom());
        word_q.push_back(w);
        issued_cnt++;
    endtask

    task automatic push_sample(input logic signed [bbsc_pkg::SAMPLE_BITS-1:0] v);
        stream_word_t w;
        w.cmd = bbsc_pkg::CMD_SAMPLE;
        w.sec = bbsc_pkg::SEC_W'($urandom());
        w.sel = bbsc_pkg::SEL_W'($urandom());
        w.cval = $urandom();
        w.smp = v;
        word_q.push_back(w);
        issued_cnt++;
    endtask

    function automatic logic signed [bbsc_pkg::SAMPLE_BITS-1:0] rand_sample();
        int k;
        k = $urandom_range(19);
        if (k == 0)
            return OUT_HI[bbsc_pkg::SAMPLE_BITS-1:0];
        if (k == 1)
            return OUT_LO[bbsc_pkg::SAMPLE_BITS-1:0];
        if (k < 10)
            return bbsc_pkg::SAMPLE_BITS'(longint'($urandom_range(32'h2_0000)) - 64'sh1_0000);
        return bbsc_pkg::SAMPLE_BITS'($urandom());
    endfunction

    function automatic int stable_coef(input logic [bbsc_pkg::SEL_W-1:0] sel);
        if (sel == bbsc_pkg::COEF_GAIN)
            return ($urandom_range(19) == 0) ? 0 : int'($urandom_range(32'h1000_0000));
        return int'(longint'($urandom_range(32'h0400_0000)) - 64'sh0200_0000);
    endfunction

    // a well-formed run: coefficient reload, then a burst of samples with some noise
    task automatic add_frame(input bit full_reload);
        int n;
        for (int s = 0; s < bbsc_pkg::SECTIONS; s++)
            for (int c = bbsc_pkg::COEF_GAIN; c <= bbsc_pkg::COEF_D4; c++)
                if (full_reload || $urandom_range(1))
                    push_load(s, bbsc_pkg::SEL_W'(c), stable_coef(bbsc_pkg::SEL_W'(c)));
        n = $urandom_range(40, 12);
        repeat (n) begin
            if ($urandom_range(9) == 0)
                push_load($urandom_range(bbsc_pkg::SECTIONS - 1),
                          bbsc_pkg::SEL_W'($urandom_range(7)), $urandom());
            push_sample(rand_sample());
        end
    endtask

    initial begin
        logic signed [bbsc_pkg::COEF_W-1:0] odd;
        logic [bbsc_pkg::MID_W-1:0] mid;
        wait (aresetn);
        @(posedge aclk);
        check_numerators();

        push_sample(OUT_HI[bbsc_pkg::SAMPLE_BITS-1:0]);
        push_sample(OUT_LO[bbsc_pkg::SAMPLE_BITS-1:0]);
        push_load(0, 3'd5, 32'h1234_5678);
        push_load(3, 3'd7, 32'hFFFF_FFFF);
        for (int s = 0; s < bbsc_pkg::SECTIONS; s++)
            push_load(s, bbsc_pkg::COEF_GAIN, 32'h1000_0000);
        push_sample(1);
        push_sample(-1);
        push_sample(0);
        push_load(0, bbsc_pkg::COEF_D1, 32'h7FFF_FFFF);
        push_load(1, bbsc_pkg::COEF_D2, 32'h8000_0000);
        push_load(2, bbsc_pkg::COEF_D3, 32'h0100_0000);
        push_load(3, bbsc_pkg::COEF_D4, -32'sh0100_0000);
        push_sample(OUT_HI[bbsc_pkg::SAMPLE_BITS-1:0]);
        push_sample(OUT_HI[bbsc_pkg::SAMPLE_BITS-1:0]);
        push_sample(OUT_LO[bbsc_pkg::SAMPLE_BITS-1:0]);
        push_sample(OUT_LO[bbsc_pkg::SAMPLE_BITS-1:0]);
        push_sample(0);
        push_sample(OUT_HI[bbsc_pkg::SAMPLE_BITS-1:0]);
        push_load(2, bbsc_pkg::COEF_GAIN, 0);
        push_sample(12345);
        push_sample(OUT_LO[bbsc_pkg::SAMPLE_BITS-1:0]);

        for (int ph = 0; ph < PHASES; ph++) begin
            wait_drained();
            repeat (70) @(posedge aclk);
            case (ph)
                0: begin odd = -32'sh4000_0000; mid = 31'h2000_0000; end
                1: begin odd = 32'sh4000_0000;  mid = 31'h6000_0000; end
                2: begin odd = '0;              mid = 31'h4000_0000; end
                default: begin
                    odd = bbsc_pkg::COEF_W'(longint'($urandom_range(32'h8000_0000))
                                            - 64'sh4000_0000);
                    mid = bbsc_pkg::MID_W'(32'h2000_0000 + $urandom_range(32'h4000_0000));
                end
            endcase
            set_numerators(odd, mid);
            if (ph == 2) begin
                tx_idle_pct = 59;
                rx_idle_pct = 12;
            end else if (ph == 4) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            add_frame(1'b1);
            while (issued_cnt < 24 + (ph + 1) * PHASE_WORDS)
                add_frame(1'b0);
        end

        wait_drained();
        repeat (80) @(posedge aclk);
        $display("covered %0d samples, %0d coefficient loads, %0d clipped words, %0d %s",
                 n_samples, n_loads, n_clipped, n_settings, "numerator settings");
        $display("idle mixes: sender-heavy, receiver-heavy, none; one %0d-cycle receiver hold-off",
                 RX_HOLD_CYCLES);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: files.f
rtl/bbsc_pkg.sv
rtl/bbsc_mul.sv
rtl/bbsc_cell.sv
rtl/butterworth_bandstop_cascade.sv
tb/sv/butterworth_bandstop_cascade_test.sv
